>>> rtl/assert_macros.svh
// Assertion macros for the frame feature extractor.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define FFE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("frame_feature_extractor: assertion failed");

// trigger implies property, non-overlapping implication
`define FFE_ASSERT_NEXT(label, trig, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error("frame_feature_extractor: assertion failed");

`endif

>>> rtl/ffe_pkg.sv
// Shared constants, controller states and command/status types for the
// frame feature extractor. No dependencies.
package ffe_pkg;

   localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;
   localparam logic [10:0] MTU_BYTES       = 11'd1500;
   localparam logic [15:0] OFFSET_LOW      = 16'd12;
   localparam logic [15:0] OFFSET_HIGH     = 16'd47;
   localparam logic [31:0] FIRST_DELTA_US  = 32'd1000;
   // ceil(2^36/1500): (cap * LEN_RECIP) >> 20 = floor(cap * 65536 / 1500) for cap <= 1500
   localparam logic [25:0] LEN_RECIP       = 26'd45812985;

   localparam int VAR_BITS   = 22;
   localparam int LEN_BITS   = 17;
   localparam int STEP_W     = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_EMPTY_OUT,
      ST_MULT,
      ST_LOAD_VAR,
      ST_DIV_VAR,
      ST_EMIT
   } ffe_state_type;

   typedef struct packed {
      logic accum;       // byte transaction to accumulate
      logic frame_end;   // final byte: snapshot and clear
      logic mult;        // register products and scaled length
      logic load_var;    // load divider for variance
      logic step;        // one quotient bit
      logic emit_frame;  // write frame result to output
      logic emit_empty;  // write default result to output
   } ffe_cmd_type;

   typedef struct packed {
      logic out_free;    // output register can take a result this cycle
   } ffe_status_type;

endpackage

>>> rtl/frame_feature_extractor.sv
// Top level of the frame feature extractor: controller plus datapath.
// Uses ffe_pkg, ffe_ctrl, ffe_datapath and assert_macros.svh.
//
//   channel | direction | carries
//   req_    | in        | frame bytes, tlast = final byte, tuser = empty frame
//   rsp_    | out       | one feature set per frame, tuser = too long
//
// Bytes are taken one per cycle while the input is ready. After a final byte the input
// stalls through products and length scaling, the divider load, a 22-step
// variance division and the result write; longer while the output slot is held.
// An empty-frame transaction stalls the input until its default result is written.
// A waiting result does not block bytes of the next frame. Synchronous reset.
`include "assert_macros.svh"

module frame_feature_extractor import ffe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // data_byte[7:0], arrival_time_us[39:8]
   input  logic                  req_tlast,
   input  logic                  req_tuser,   // empty_frame[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // length_ratio[16:0], arrival_gap_us[48:17],
                                              // protocol_byte[56:49], byte_spread[78:57]
   output logic                  rsp_tuser    // too_long[0]
);

   ffe_cmd_type    cmd;
   ffe_status_type status;

   ffe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_empty  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ffe_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .data_byte       (req_tdata[7:0]),
      .arrival_time_us (req_tdata[39:8]),
      .cmd             (cmd),
      .status          (status),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser)
   );

   `FFE_ASSERT(a_emit_slot_free, (cmd.emit_frame || cmd.emit_empty) |-> (!rsp_tvalid || rsp_tready))
   `FFE_ASSERT_NEXT(a_empty_stalls, req_tvalid && req_tready && req_tuser, !req_tready)
   `FFE_ASSERT_NEXT(a_frame_end_stalls, cmd.frame_end, !req_tready)
   `FFE_ASSERT(a_long_has_length, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[16:0] != 17'd0))

endmodule

>>> rtl/ffe_datapath.sv
// Datapath: per-frame accumulators, timing state, products, reciprocal length
// scaling, restoring divider for the variance and output register. Uses ffe_pkg.
module ffe_datapath import ffe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            data_byte,
   input  logic [31:0]           arrival_time_us,
   input  ffe_cmd_type           cmd,
   output ffe_status_type        status,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   // frame accumulators
   logic [15:0] count_ff, count_in;
   logic [23:0] total_ff, total_in;
   logic [31:0] square_ff, square_in;
   logic [7:0]  b12_ff, b12_in;
   logic [7:0]  b47_ff, b47_in;
   logic        ovf_ff, ovf_in;

   // timing
   logic [31:0] prev_time_ff;
   logic        has_prev_ff;

   // frame snapshot
   logic [15:0] n_snap_ff;
   logic [23:0] tot_snap_ff;
   logic [31:0] sq_snap_ff;
   logic [7:0]  proto_snap_ff, proto_in;
   logic [10:0] cap_snap_ff, cap_in;
   logic [31:0] delta_snap_ff, delta_in;
   logic        long_snap_ff;

   // products
   logic [47:0]         p_nsq_ff, p_tot_ff;
   logic [31:0]         p_den_ff;
   logic [47:0]         spread;
   logic [36:0]         len_prod;
   logic [LEN_BITS-1:0] len_ff;

   // divider
   logic [32:0]         rem_ff, rem_in, rem_shift;
   logic [VAR_BITS-1:0] low_ff, low_in;
   logic [31:0]         dvsr_ff, dvsr_in;
   logic [VAR_BITS-1:0] quo_ff, quo_in;
   logic                fits;

   // output
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_user_ff;

   always_comb begin
      count_in  = count_ff;
      total_in  = total_ff;
      square_in = square_ff;
      b12_in    = b12_ff;
      b47_in    = b47_ff;
      ovf_in    = ovf_ff;
      if (count_ff < MAX_FRAME_BYTES) begin
         if (count_ff == OFFSET_LOW) begin
            b12_in = data_byte;
         end
         if (count_ff == OFFSET_HIGH) begin
            b47_in = data_byte;
         end
         count_in  = count_ff + 16'd1;
         total_in  = total_ff + {16'd0, data_byte};
         square_in = square_ff + {16'd0, 16'(data_byte * data_byte)};
      end else begin
         ovf_in = 1'b1;
      end
      if (count_in > OFFSET_HIGH) begin
         proto_in = b47_in;
      end else if (count_in > OFFSET_LOW) begin
         proto_in = b12_in;
      end else begin
         proto_in = 8'd0;
      end
      cap_in   = (count_in > {5'd0, MTU_BYTES}) ? MTU_BYTES : count_in[10:0];
      delta_in = has_prev_ff ? (arrival_time_us - prev_time_ff) : FIRST_DELTA_US;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         square_ff    <= '0;
         b12_ff       <= '0;
         b47_ff       <= '0;
         ovf_ff       <= 1'b0;
         prev_time_ff <= '0;
         has_prev_ff  <= 1'b0;
      end else if (cmd.frame_end) begin
         count_ff     <= '0;
         total_ff     <= '0;
         square_ff    <= '0;
         b12_ff       <= '0;
         b47_ff       <= '0;
         ovf_ff       <= 1'b0;
         prev_time_ff <= arrival_time_us;
         has_prev_ff  <= 1'b1;
      end else if (cmd.accum) begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         square_ff    <= square_in;
         b12_ff       <= b12_in;
         b47_ff       <= b47_in;
         ovf_ff       <= ovf_in;
      end
   end

   // capped length times the scaled reciprocal of 1500
   assign len_prod = {26'd0, cap_snap_ff} * {11'd0, LEN_RECIP};

   always_ff @(posedge clock) begin
      if (cmd.frame_end) begin
         n_snap_ff     <= count_in;
         tot_snap_ff   <= total_in;
         sq_snap_ff    <= square_in;
         proto_snap_ff <= proto_in;
         cap_snap_ff   <= cap_in;
         delta_snap_ff <= delta_in;
         long_snap_ff  <= ovf_in;
      end
      if (cmd.mult) begin
         p_nsq_ff <= {32'd0, n_snap_ff} * {16'd0, sq_snap_ff};
         p_tot_ff <= {24'd0, tot_snap_ff} * {24'd0, tot_snap_ff};
         p_den_ff <= {16'd0, n_snap_ff} * {16'd0, n_snap_ff};
         len_ff   <= len_prod[36:20];
      end
   end

   // N*sumsq - sum^2, never negative; quotient fits VAR_BITS so the
   // top of the shifted numerator starts below the divisor
   assign spread = p_nsq_ff - p_tot_ff;

   always_comb begin
      rem_shift = {rem_ff[31:0], low_ff[VAR_BITS-1]};
      fits      = rem_shift >= {1'b0, dvsr_ff};
      rem_in    = rem_ff;
      low_in    = low_ff;
      dvsr_in   = dvsr_ff;
      quo_in    = quo_ff;
      if (cmd.load_var) begin
         rem_in  = {1'b0, spread[45:14]};
         low_in  = {spread[13:0], 8'd0};
         dvsr_in = p_den_ff;
         quo_in  = '0;
      end else if (cmd.step) begin
         rem_in = fits ? (rem_shift - {1'b0, dvsr_ff}) : rem_shift;
         low_in = {low_ff[VAR_BITS-2:0], 1'b0};
         quo_in = {quo_ff[VAR_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      dvsr_ff <= dvsr_in;
      quo_ff  <= quo_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_frame || cmd.emit_empty) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_frame) begin
         out_data_ff <= {1'b0, quo_ff, proto_snap_ff, delta_snap_ff, len_ff};
         out_user_ff <= long_snap_ff;
      end else if (cmd.emit_empty) begin
         out_data_ff <= {1'b0, 22'd0, 8'd0, FIRST_DELTA_US, 17'd0};
         out_user_ff <= 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_data_ff;
   assign rsp_tuser       = out_user_ff;

endmodule

>>> rtl/ffe_ctrl.sv
// Controller: sequences accumulation, products, the variance division and
// the result write. Uses ffe_pkg.
module ffe_ctrl import ffe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tlast,
   input  logic           req_empty,
   output logic           req_tready,
   input  ffe_status_type status,
   output ffe_cmd_type    cmd
);

   ffe_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      accept     = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept && req_empty) begin
               state_in = ST_EMPTY_OUT;
            end else if (accept) begin
               cmd.accum = 1'b1;
               if (req_tlast) begin
                  cmd.frame_end = 1'b1;
                  state_in      = ST_MULT;
               end
            end
         end
         ST_EMPTY_OUT: begin
            if (status.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in       = ST_ACCUM;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_LOAD_VAR;
         end
         ST_LOAD_VAR: begin
            cmd.load_var = 1'b1;
            step_in      = STEP_W'(VAR_BITS - 1);
            state_in     = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            cmd.step = 1'b1;
            step_in  = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_frame = 1'b1;
               state_in       = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule
